/* src/idp_pkg.sv */
`default_nettype none

package idp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SIGNED_INPUT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BIAS_ENABLE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WGT_ADJ      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SUM_ENABLE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SUM_SCALE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEST_TYPE    = 3'd5;

  // Destination type codes; anything else is s32
  localparam logic [1:0] DEST_S32 = 2'd0;
  localparam logic [1:0] DEST_S8  = 2'd1;
  localparam logic [1:0] DEST_U8  = 2'd2;

  typedef logic signed [16:0] quad_sum_t;

  // Saturate a pair sum to int16
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/idp_if.sv */
`default_nettype none

interface idp_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        act_quad;
  logic [31:0]        wgt_quad;
  logic               last_quad;
  logic signed [31:0] bias_value;
  logic signed [31:0] compensation;
  logic signed [31:0] out_scale;
  logic signed [31:0] prev_dest;

  modport source (
    output valid, act_quad, wgt_quad, last_quad, bias_value, compensation, out_scale,
    prev_dest,
    input  ready
  );
  modport sink (
    input  valid, act_quad, wgt_quad, last_quad, bias_value, compensation, out_scale,
    prev_dest,
    output ready
  );
endinterface

interface idp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

interface idp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [idp_pkg::CfgIdxW-1:0]  index;
  logic [31:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/idp_mac.sv */
`default_nettype none

// Four byte products, summed in pairs, each pair saturated to int16.
module idp_mac (
  input  wire logic [31:0]        act_i,
  input  wire logic [31:0]        wgt_i,
  input  wire logic               signed_input_i,
  output idp_pkg::quad_sum_t      sum_o
);

  logic [31:0]               act;
  logic signed [16:0]        prod [4];
  logic signed [15:0]        pair [2];

  // Flip the top bit of each byte to move s8 into the u8 range
  assign act = signed_input_i ? (act_i ^ 32'h8080_8080) : act_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = $signed({1'b0, act[8*k +: 8]}) * $signed(wgt_i[8*k +: 8]);
    end
    for (int p = 0; p < 2; p++) begin
      pair[p] = idp_pkg::sat16(18'(prod[2*p]) + 18'(prod[2*p+1]));
    end
  end

  assign sum_o = 17'(pair[0]) + 17'(pair[1]);

endmodule

`default_nettype wire

/* src/idp_mul.sv */
`default_nettype none

// Shared signed multiplier with registered product.
module idp_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [63:0]      p_o
);

  logic signed [65:0] full;
  logic signed [63:0] p_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= full[63:0];
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* src/int8_dot_product_requantize_unit.sv */
`default_nettype none

// int8 dot product with requantization. Each request carries four activation
// and four weight bytes; a request without last_quad only accumulates, and
// requests of that kind can follow back to back while the sequencer is idle. A
// request with last_quad set also runs the requantization through one shared
// 33x33 multiplier (adjusted bias, output scale, sum scale) under a small
// sequencer: after accepting it the block is busy through the BIAS, PRE, SCALE,
// SUM, ADD and ROUND states and holds in ROUND while the result slot stays full.
// Results are RNE rounded and saturated to the configured destination type;
// scales carry SCALE_FRAC_BITS fraction bits.
module int8_dot_product_requantize_unit #(
  parameter int unsigned SCALE_FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  idp_in_if.sink     in_i,
  idp_out_if.source  out_o,
  idp_cfg_if.sink    cfg_i
);

  localparam int unsigned F = SCALE_FRAC_BITS;
  localparam logic [31:0] ScaleOne = 32'(64'd1 << F);
  localparam logic [F-1:0] RndHalf = {1'b1, {(F-1){1'b0}}};
  localparam logic signed [65:0] Int32Max66 = 66'sd2147483647;
  localparam logic signed [65:0] Int32Min66 = -66'sd2147483648;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BIAS  = 3'd1;
  localparam logic [2:0] ST_PRE   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_ROUND = 3'd6;

  function automatic logic signed [63:0] rne(input logic signed [63:0] v);
    logic signed [63:0] q;
    logic [F-1:0]       r;
    logic               up;
    q  = v >>> F;
    r  = v[F-1:0];
    up = (r > RndHalf) || ((r == RndHalf) && q[0]);
    return q + 64'(up);
  endfunction

  // Configuration registers
  logic        signed_input_q, bias_enable_q, sum_enable_q;
  logic [31:0] wgt_adj_q, sum_scale_q;
  logic [1:0]  dest_type_q;

  logic [2:0]  state_q, state_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q;
  logic signed [31:0] result_q;

  // Payload of the last request
  logic signed [31:0] bias_q, comp_q, oscale_q, prev_q;
  logic signed [31:0] pre_q;
  logic signed [63:0] scaled_q, total_q;

  idp_pkg::quad_sum_t quad_sum;
  logic               in_fire, out_fire, slot_free, emit;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] bias_term, round_val, lo, hi;
  logic signed [65:0] pre_sum;
  logic signed [64:0] sum65;
  logic signed [63:0] sat_total;
  logic signed [63:0] clamp_val;

  idp_mac u_mac (
    .act_i          (in_i.act_quad),
    .wgt_i          (in_i.wgt_quad),
    .signed_input_i (signed_input_q),
    .sum_o          (quad_sum)
  );

  idp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign out_fire     = out_o.valid && out_o.ready;
  assign slot_free    = !out_valid_q || out_o.ready;
  assign emit         = (state_q == ST_ROUND) && slot_free;
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = out_valid_q;
  assign out_o.result_value = result_q;

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      ST_BIAS: begin
        mul_a = 33'(bias_q);
        mul_b = $signed({1'b0, wgt_adj_q});
      end
      ST_SUM: begin
        mul_a = 33'(prev_q);
        mul_b = 33'($signed(sum_scale_q));
      end
      default: begin
        mul_a = 33'(pre_q);
        mul_b = 33'(oscale_q);
      end
    endcase
  end

  always_comb begin
    bias_term = signed_input_q ? rne(mul_p) : 64'(bias_q);
    pre_sum   = 66'($signed(acc_q))
              + (signed_input_q ? 66'(comp_q) : 66'sd0)
              + (bias_enable_q ? 66'(bias_term) : 66'sd0);

    sum65 = 65'(scaled_q) + 65'(mul_p);
    if (sum65[64] != sum65[63]) begin
      sat_total = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_total = sum65[63:0];
    end

    round_val = rne(total_q);
    case (dest_type_q)
      idp_pkg::DEST_S8: begin
        lo = -64'sd128;
        hi = 64'sd127;
      end
      idp_pkg::DEST_U8: begin
        lo = 64'sd0;
        hi = 64'sd255;
      end
      default: begin
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
      end
    endcase
    if (round_val < lo) begin
      clamp_val = lo;
    end else if (round_val > hi) begin
      clamp_val = hi;
    end else begin
      clamp_val = round_val;
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    if (in_fire) begin
      acc_d = acc_q + 32'(quad_sum);
      if (in_i.last_quad) begin
        state_d = ST_BIAS;
      end
    end
    case (state_q)
      ST_BIAS:  state_d = ST_PRE;
      ST_PRE:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_ROUND;
      ST_ROUND: begin
        if (slot_free) begin
          state_d = ST_IDLE;
          acc_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      acc_q          <= '0;
      out_valid_q    <= 1'b0;
      signed_input_q <= 1'b0;
      bias_enable_q  <= 1'b0;
      wgt_adj_q      <= ScaleOne;
      sum_enable_q   <= 1'b0;
      sum_scale_q    <= ScaleOne;
      dest_type_q    <= idp_pkg::DEST_S32;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          idp_pkg::REG_SIGNED_INPUT: signed_input_q <= cfg_i.data[0];
          idp_pkg::REG_BIAS_ENABLE:  bias_enable_q  <= cfg_i.data[0];
          idp_pkg::REG_WGT_ADJ:      wgt_adj_q      <= cfg_i.data;
          idp_pkg::REG_SUM_ENABLE:   sum_enable_q   <= cfg_i.data[0];
          idp_pkg::REG_SUM_SCALE:    sum_scale_q    <= cfg_i.data;
          idp_pkg::REG_DEST_TYPE:    dest_type_q    <= cfg_i.data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bias_q   <= in_i.bias_value;
      comp_q   <= in_i.compensation;
      oscale_q <= in_i.out_scale;
      prev_q   <= in_i.prev_dest;
    end
    if (state_q == ST_PRE) begin
      if (pre_sum > Int32Max66) begin
        pre_q <= Int32Max66[31:0];
      end else if (pre_sum < Int32Min66) begin
        pre_q <= Int32Min66[31:0];
      end else begin
        pre_q <= pre_sum[31:0];
      end
    end
    if (state_q == ST_SUM) begin
      scaled_q <= mul_p;
    end
    if (state_q == ST_ADD) begin
      total_q <= sum_enable_q ? sat_total : scaled_q;
    end
    if (emit) begin
      result_q <= clamp_val[31:0];
    end
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input ready while sequencer busy");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_quad) |=> (state_q == ST_BIAS))
    else $error("last request did not start requantization");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && (acc_q == 32'd0) && (state_q == ST_IDLE)))
    else $error("result not posted or accumulator not cleared");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(result_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
